[rtl/assert_macros.svh]
// Shared assertion macros for the deframer checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define CPD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("deframer check failed");

// Checked at every clock edge, reset included.
`define CPD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("deframer reset check failed");

`endif

[rtl/cpd_pkg.sv]
`default_nettype none

package cpd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;

   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 6;
   localparam int INDEX_W = 5;

   typedef enum logic [STAT_W-1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_LENGTH   = 2'd2
   } cpd_status_type;

   typedef struct packed {
      logic                 single;
      logic                 run;
      logic [BYTE_W-1:0]    frame_id;
      cpd_status_type       status;
      logic [COUNT_W-1:0]   count;
   } cpd_event_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    frame_id;
      logic [STAT_W-1:0]    status;
      logic [COUNT_W-1:0]   payload_count;
      logic [INDEX_W-1:0]   byte_index;
      logic [BYTE_W-1:0]    payload_byte;
      logic                 has_data;
      logic                 last;
   } cpd_result_type;

endpackage

`default_nettype wire

[rtl/cpd_interfaces.sv]
`default_nettype none

interface cpd_req_if;
   import cpd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_rsp_if;
   import cpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  frame_id;
   logic [STAT_W-1:0]  status;
   logic [COUNT_W-1:0] payload_count;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  payload_byte;
   logic               has_data;
   logic               last;

   modport source (output valid, output frame_id, output status, output payload_count,
                   output byte_index, output payload_byte, output has_data,
                   output last, input ready);
   modport sink (input valid, input frame_id, input status, input payload_count,
                 input byte_index, input payload_byte, input has_data, input last,
                 output ready);
endinterface

`default_nettype wire

[rtl/cpd_payload_buffer.sv]
`default_nettype none

module cpd_payload_buffer
   import cpd_pkg::*;
#(
   parameter int DEPTH  = MAX_PAYLOAD_DEFAULT,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/cpd_frame_parser.sv]
`default_nettype none

module cpd_frame_parser
   import cpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
   parameter int CNT_W       = 6,
   parameter int ADDR_W      = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cpd_req_if.sink                req_if,
   input  wire logic              draining,
   input  wire logic              out_free,
   output cpd_event_type          ev,
   output logic      [CNT_W-1:0]  run_length,
   output logic                   wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [BYTE_W-1:0] wr_data
);

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_SUM  = 2'd3
   } phase_type;

   localparam logic [BYTE_W-1:0] LEN_LIMIT = BYTE_W'(MAX_PAYLOAD + 1);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] held_id_ff, held_id_in;
   logic [CNT_W-1:0]  held_length_ff, held_length_in;
   logic [CNT_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] sum_add;
   logic              accept;
   logic              needs_out;

   always_comb begin
      needs_out      = (phase_ff == PH_LEN) || (phase_ff == PH_SUM);
      req_if.ready   = !draining && (!needs_out || out_free);
      accept         = req_if.valid && req_if.ready;
      sum_add        = sum_ff + req_if.rx_byte;

      phase_in       = phase_ff;
      held_id_in     = held_id_ff;
      held_length_in = held_length_ff;
      bytes_seen_in  = bytes_seen_ff;
      sum_in         = sum_ff;

      ev             = '0;
      ev.frame_id    = held_id_ff;
      ev.status      = STATUS_GOOD;
      run_length     = held_length_ff;
      wr_en          = 1'b0;
      wr_addr        = bytes_seen_ff[ADDR_W-1:0];
      wr_data        = req_if.rx_byte;

      case (phase_ff)
         PH_ID: begin
            if (accept) begin
               held_id_in     = req_if.rx_byte;
               sum_in         = req_if.rx_byte;
               bytes_seen_in  = '0;
               held_length_in = '0;
               phase_in       = PH_LEN;
            end
         end
         PH_LEN: begin
            if (accept) begin
               sum_in = sum_add;
               if ((req_if.rx_byte == '0) || (req_if.rx_byte > LEN_LIMIT)) begin
                  ev.single = 1'b1;
                  ev.status = STATUS_LENGTH;
                  ev.count  = '0;
                  phase_in  = PH_ID;
               end else begin
                  held_length_in = CNT_W'(req_if.rx_byte - 8'd1);
                  bytes_seen_in  = '0;
                  phase_in       = (req_if.rx_byte == 8'd1) ? PH_SUM : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            wr_en = accept;
            if (accept) begin
               sum_in        = sum_add;
               bytes_seen_in = bytes_seen_ff + 1'b1;
               if (bytes_seen_in >= held_length_ff) begin
                  phase_in = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (accept) begin
               if (req_if.rx_byte == ~sum_ff) begin
                  if (held_length_ff == '0) begin
                     ev.single = 1'b1;
                     ev.status = STATUS_GOOD;
                     ev.count  = '0;
                  end else begin
                     ev.run    = 1'b1;
                     ev.count  = COUNT_W'(held_length_ff);
                  end
               end else begin
                  ev.single = 1'b1;
                  ev.status = STATUS_CHECKSUM;
                  ev.count  = COUNT_W'(held_length_ff);
               end
               phase_in = PH_ID;
            end
         end
         default: begin
            phase_in = PH_ID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_ID;
         held_id_ff     <= '0;
         held_length_ff <= '0;
         bytes_seen_ff  <= '0;
         sum_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         held_id_ff     <= held_id_in;
         held_length_ff <= held_length_in;
         bytes_seen_ff  <= bytes_seen_in;
         sum_ff         <= sum_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cpd_output_sequencer.sv]
`default_nettype none

module cpd_output_sequencer
   import cpd_pkg::*;
#(
   parameter int CNT_W  = 6,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cpd_event_type          ev,
   input  wire logic [CNT_W-1:0]  run_length,
   output logic                   draining,
   output logic                   out_free,
   output logic                   rd_en,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [BYTE_W-1:0] rd_data,
   cpd_rsp_if.source              rsp_if
);

   logic              out_valid_ff, out_valid_in;
   cpd_result_type    result_ff, result_in;
   logic              draining_ff, draining_in;
   logic              fetched_ff, fetched_in;
   logic [BYTE_W-1:0] run_id_ff, run_id_in;
   logic [CNT_W-1:0]  run_len_ff, run_len_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  fetch_idx_ff, fetch_idx_in;
   logic              load;
   logic              issue;
   logic              is_last;

   always_comb begin
      out_free = !out_valid_ff || rsp_if.ready;
      load     = fetched_ff && out_free;
      issue    = draining_ff && (rd_idx_ff < run_len_ff) && (!fetched_ff || load);
      is_last  = (CNT_W'(fetch_idx_ff + 1'b1) == run_len_ff);
      draining = draining_ff;
      rd_en    = issue;
      rd_addr  = rd_idx_ff[ADDR_W-1:0];

      out_valid_in = out_valid_ff && !rsp_if.ready;
      result_in    = result_ff;
      draining_in  = draining_ff;
      fetched_in   = fetched_ff;
      run_id_in    = run_id_ff;
      run_len_in   = run_len_ff;
      rd_idx_in    = rd_idx_ff;
      fetch_idx_in = fetch_idx_ff;

      if (ev.single) begin
         out_valid_in            = 1'b1;
         result_in.frame_id      = ev.frame_id;
         result_in.status        = ev.status;
         result_in.payload_count = ev.count;
         result_in.byte_index    = '0;
         result_in.payload_byte  = '0;
         result_in.has_data      = 1'b0;
         result_in.last          = 1'b1;
      end

      if (ev.run) begin
         draining_in = 1'b1;
         run_id_in   = ev.frame_id;
         run_len_in  = run_length;
         rd_idx_in   = '0;
         fetched_in  = 1'b0;
      end

      if (issue) begin
         rd_idx_in    = rd_idx_ff + 1'b1;
         fetch_idx_in = rd_idx_ff;
         fetched_in   = 1'b1;
      end else if (load) begin
         fetched_in = 1'b0;
      end

      if (load) begin
         out_valid_in            = 1'b1;
         result_in.frame_id      = run_id_ff;
         result_in.status        = STATUS_GOOD;
         result_in.payload_count = COUNT_W'(run_len_ff);
         result_in.byte_index    = INDEX_W'(fetch_idx_ff);
         result_in.payload_byte  = rd_data;
         result_in.has_data      = 1'b1;
         result_in.last          = is_last;
         if (is_last) begin
            draining_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         draining_ff  <= 1'b0;
         fetched_ff   <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         draining_ff  <= draining_in;
         fetched_ff   <= fetched_in;
      end
      result_ff    <= result_in;
      run_id_ff    <= run_id_in;
      run_len_ff   <= run_len_in;
      rd_idx_ff    <= rd_idx_in;
      fetch_idx_ff <= fetch_idx_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.frame_id      = result_ff.frame_id;
   assign rsp_if.status        = result_ff.status;
   assign rsp_if.payload_count = result_ff.payload_count;
   assign rsp_if.byte_index    = result_ff.byte_index;
   assign rsp_if.payload_byte  = result_ff.payload_byte;
   assign rsp_if.has_data      = result_ff.has_data;
   assign rsp_if.last          = result_ff.last;

endmodule

`default_nettype wire

[rtl/checksummed_packet_deframer_unit.sv]
// Deframer for length-prefixed link frames with an inverted-sum checksum.
// The req_if channel takes one received byte per transaction; the rsp_if
// channel returns results, each tagged with the frame id and a status.
// Id, length and payload bytes are taken one per cycle while no drain runs
// and, for a length byte, the output register is free; payload bytes are
// written into a one-port-write, one-port-read buffer as they arrive.
// A length or checksum byte that ends in a single result (error or empty
// frame) needs a free output register; that result shows in the next cycle.
// A good checksum byte starts a drain through the buffer's registered read
// port: one result per cycle while the receiver keeps rsp_if.ready high.
// A frame of N payload bytes costs N + 3 input transactions, and req_if.ready
// stays low while its payload drains.
// When the receiver stalls, the waiting result holds and the drain pauses;
// id and payload bytes are still accepted while a single result waits.
// Synchronous reset returns the block to hunting for an id byte and empties
// the output register; the payload buffer needs no clearing because only
// entries written in the current frame are read.
`default_nettype none

module checksummed_packet_deframer_unit
   import cpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   cpd_req_if.sink   req_if,
   cpd_rsp_if.source rsp_if
);

   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   cpd_event_type     ev;
   logic [CNT_W-1:0]  run_length;
   logic              draining;
   logic              out_free;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;

   cpd_frame_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .CNT_W       (CNT_W),
      .ADDR_W      (ADDR_W)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .draining   (draining),
      .out_free   (out_free),
      .ev         (ev),
      .run_length (run_length),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   cpd_payload_buffer #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpd_output_sequencer #(
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .ev         (ev),
      .run_length (run_length),
      .draining   (draining),
      .out_free   (out_free),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

[rtl/cpd_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module cpd_checker
   import cpd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [BYTE_W-1:0]  rsp_frame_id,
   input wire logic [STAT_W-1:0]  rsp_status,
   input wire logic [COUNT_W-1:0] rsp_payload_count,
   input wire logic [INDEX_W-1:0] rsp_byte_index,
   input wire logic [BYTE_W-1:0]  rsp_payload_byte,
   input wire logic               rsp_has_data,
   input wire logic               rsp_last
);

   cpd_result_type rsp_fields;
   logic           rsp_spare_zero;

   assign rsp_fields = {rsp_frame_id, rsp_status, rsp_payload_count, rsp_byte_index,
                        rsp_payload_byte, rsp_has_data, rsp_last};
   assign rsp_spare_zero = (rsp_byte_index == '0) && (rsp_payload_byte == '0);

   // A stalled result holds all of its fields.
   `CPD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fields))

   // Only a good frame carries payload bytes.
   `CPD_ASSERT(a_data_is_good, rsp_valid && rsp_has_data |-> rsp_status == STATUS_GOOD)

   // A result without payload stands alone and has its unused fields cleared.
   `CPD_ASSERT(a_empty_result, rsp_valid && !rsp_has_data |-> rsp_last && rsp_spare_zero)

   // While a payload run is still being delivered, no new byte is taken.
   `CPD_ASSERT(a_run_blocks_input, rsp_valid && rsp_has_data && !rsp_last |-> !req_ready)

   // Reset empties the output register.
   `CPD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)

endmodule

bind checksummed_packet_deframer_unit cpd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_frame_id      (rsp_if.frame_id),
   .rsp_status        (rsp_if.status),
   .rsp_payload_count (rsp_if.payload_count),
   .rsp_byte_index    (rsp_if.byte_index),
   .rsp_payload_byte  (rsp_if.payload_byte),
   .rsp_has_data      (rsp_if.has_data),
   .rsp_last          (rsp_if.last)
);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   import cpd_pkg::*;

   typedef logic [BYTE_W-1:0] link_byte_type;

   typedef enum logic [1:0] {
      HUNT_ID,
      HUNT_LENGTH,
      TAKE_PAYLOAD,
      TAKE_CHECKSUM
   } link_phase_type;

   localparam int STALL_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 150;
   localparam int HOLDOFF_AFTER  = 60;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_TARGET  = 270;
   localparam int REPORT_LIMIT   = 10;

   logic clock = 1'b0;
   logic reset;

   cpd_req_if req_bus ();
   cpd_rsp_if rsp_bus ();

   checksummed_packet_deframer_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #10 clock = ~clock;

   link_byte_type  pending_bytes[$];
   link_byte_type  frame_body[$];
   cpd_result_type expected_results[$];

   link_phase_type             link_phase = HUNT_ID;
   link_byte_type              held_id = '0;
   logic [COUNT_W-1:0]         held_count = '0;
   logic [COUNT_W-1:0]         bytes_seen = '0;
   link_byte_type              running_sum = '0;
   link_byte_type              payload_store[MAX_PAYLOAD_DEFAULT];

   int bytes_accepted = 0;
   int mismatches = 0;
   int payload_results = 0;
   int empty_frames = 0;
   int checksum_errors = 0;
   int length_errors = 0;
   int stall_cycles = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   wire quiet_stretch = (bytes_accepted >= 150) && (bytes_accepted < 210);

   // Advances the frame parser by one received byte and queues the results it releases.
   task automatic deframe_byte(input link_byte_type b);
      cpd_result_type r;
      int i;
      r = '0;
      r.frame_id = held_id;
      r.last = 1'b1;
      case (link_phase)
         HUNT_ID: begin
            held_id = b;
            running_sum = b;
            bytes_seen = '0;
            held_count = '0;
            link_phase = HUNT_LENGTH;
         end
         HUNT_LENGTH: begin
            running_sum = running_sum + b;
            if (b == 0 || b > MAX_PAYLOAD_DEFAULT + 1) begin
               r.status = STATUS_LENGTH;
               expected_results.push_back(r);
               link_phase = HUNT_ID;
            end else begin
               held_count = COUNT_W'(b - 8'd1);
               bytes_seen = '0;
               link_phase = (held_count == 0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            if (bytes_seen < MAX_PAYLOAD_DEFAULT) begin
               payload_store[bytes_seen[INDEX_W-1:0]] = b;
            end
            running_sum = running_sum + b;
            bytes_seen = bytes_seen + 1'b1;
            if (bytes_seen >= held_count) begin
               link_phase = TAKE_CHECKSUM;
            end
         end
         default: begin
            if (b == link_byte_type'(~running_sum)) begin
               r.status = STATUS_GOOD;
               if (held_count == 0) begin
                  expected_results.push_back(r);
               end else begin
                  for (i = 0; i < held_count && i < MAX_PAYLOAD_DEFAULT; i++) begin
                     r.payload_count = held_count;
                     r.byte_index = i[INDEX_W-1:0];
                     r.payload_byte = payload_store[i[INDEX_W-1:0]];
                     r.has_data = 1'b1;
                     r.last = (i + 1 == held_count);
                     expected_results.push_back(r);
                  end
               end
            end else begin
               r.status = STATUS_CHECKSUM;
               r.payload_count = held_count;
               expected_results.push_back(r);
            end
            link_phase = HUNT_ID;
         end
      endcase
   endtask

   task automatic fill_random_body(input int n);
      repeat (n) frame_body.push_back(link_byte_type'($urandom_range(0, 255)));
   endtask

   // Queues id, length, the body held in frame_body and a checksum, spoiled on request.
   task automatic add_frame(input link_byte_type id, input bit corrupt);
      link_byte_type sum;
      link_byte_type length_byte;
      length_byte = link_byte_type'(frame_body.size() + 1);
      sum = id + length_byte;
      pending_bytes.push_back(id);
      pending_bytes.push_back(length_byte);
      foreach (frame_body[k]) begin
         pending_bytes.push_back(frame_body[k]);
         sum = sum + frame_body[k];
      end
      sum = ~sum;
      if (corrupt) begin
         sum = sum ^ link_byte_type'($urandom_range(1, 255));
      end
      pending_bytes.push_back(sum);
      frame_body.delete();
   endtask

   function automatic int pick_payload_size();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(9, MAX_PAYLOAD_DEFAULT);
      end
      return $urandom_range(0, 8);
   endfunction

   initial begin
      int pick;
      reset = 1'b1;

      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(link_byte_type'(MAX_PAYLOAD_DEFAULT + 2));
      pending_bytes.push_back(8'h5A);
      pending_bytes.push_back(8'hFF);
      add_frame(8'h00, 1'b0);
      add_frame(8'hFF, 1'b1);
      frame_body.push_back(8'h00);
      frame_body.push_back(8'hFF);
      add_frame(8'hA5, 1'b0);
      frame_body.push_back(8'h80);
      add_frame(8'h3C, 1'b1);

      fill_random_body(MAX_PAYLOAD_DEFAULT);
      add_frame(link_byte_type'($urandom_range(0, 255)), 1'b0);
      while (pending_bytes.size() < RANDOM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            fill_random_body(pick_payload_size());
            add_frame(link_byte_type'($urandom_range(0, 255)), pick >= 70);
         end else if (pick < 92) begin
            pending_bytes.push_back(link_byte_type'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) begin
               pending_bytes.push_back(8'h00);
            end else begin
               pending_bytes.push_back(
                  link_byte_type'($urandom_range(MAX_PAYLOAD_DEFAULT + 2, 255)));
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               pending_bytes.push_back(link_byte_type'($urandom_range(0, 255)));
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d link bytes; checked %0d payload bytes, %0d empty frames,",
               bytes_accepted, payload_results, empty_frames);
      $display("%0d checksum errors and %0d length errors, with %0d mismatches.",
               checksum_errors, length_errors, mismatches);
      if (mismatches == 0) begin
         $display("checksummed_packet_deframer_unit test passed");
      end else begin
         $display("checksummed_packet_deframer_unit test failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.rx_byte <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            deframe_byte(req_bus.rx_byte);
            bytes_accepted <= bytes_accepted + 1;
            void'(pending_bytes.pop_front());
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 &&
                (quiet_stretch || $urandom_range(0, 99) >= 36)) begin
               req_bus.valid <= 1'b1;
               req_bus.rx_byte <= pending_bytes[0];
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      cpd_result_type seen;
      cpd_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.frame_id = rsp_bus.frame_id;
            seen.status = rsp_bus.status;
            seen.payload_count = rsp_bus.payload_count;
            seen.byte_index = rsp_bus.byte_index;
            seen.payload_byte = rsp_bus.payload_byte;
            seen.has_data = rsp_bus.has_data;
            seen.last = rsp_bus.last;
            if (expected_results.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("Unexpected result: id %h status %0d count %0d", seen.frame_id,
                           seen.status, seen.payload_count);
               end
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("Mismatch: expected id %h st %0d cnt %0d idx %0d byte %h d %b l %b",
                              want.frame_id, want.status, want.payload_count,
                              want.byte_index, want.payload_byte, want.has_data, want.last);
                     $display("          actual   id %h st %0d cnt %0d idx %0d byte %h d %b l %b",
                              seen.frame_id, seen.status, seen.payload_count,
                              seen.byte_index, seen.payload_byte, seen.has_data, seen.last);
                  end
                  mismatches++;
               end
               case (want.status)
                  STATUS_GOOD: begin
                     if (want.has_data) begin
                        payload_results++;
                     end else begin
                        empty_frames++;
                     end
                  end
                  STATUS_CHECKSUM: checksum_errors++;
                  default: length_errors++;
               endcase
            end
         end

         // One long hold-off lets the block fill up and stall its input.
         if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!holdoff_done && bytes_accepted >= HOLDOFF_AFTER) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet_stretch || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (pending_bytes.size() == 0 && expected_results.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("No transaction for %0d cycles with work outstanding.", stall_cycles);
         $display("checksummed_packet_deframer_unit test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

`default_nettype wire
